// ===== rtl/vwvf_pkg.sv =====
// shared constants and types for the view window vertex filter
// no dependencies; compiled before every other file
package vwvf_pkg;

	localparam int unsigned COORD_W      = 32;
	localparam int unsigned NUM_W        = 16;
	localparam int unsigned VIEW_W       = 16;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 64;
	localparam int unsigned DEPTH_REG_W  = 17;
	localparam int unsigned MAX_VERTICES = 65536;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAT_X_LO   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAT_X_HI   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAT_Y_LO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAT_Y_HI   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAT_Z_LO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAT_Z_HI   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 3'd7;

	// reset values: identity matrix, zero window, min depth -2.0, rectangle mode
	localparam logic [CFG_DATA_W-1:0]  RST_MAT_X_LO   = 64'h0000_0000_0001_0000;
	localparam logic [CFG_DATA_W-1:0]  RST_MAT_X_HI   = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0]  RST_MAT_Y_LO   = 64'h0001_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0]  RST_MAT_Y_HI   = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0]  RST_MAT_Z_LO   = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0]  RST_MAT_Z_HI   = 64'h0000_0000_0001_0000;
	localparam logic [CFG_DATA_W-1:0]  RST_WINDOW     = 64'h0000_0000_0000_0000;
	localparam logic [DEPTH_REG_W-1:0] RST_DEPTH_MODE = 17'h0_8000;

	// one row of the affine matrix, Q16.16 coefficients
	typedef struct packed {
		logic signed [COORD_W-1:0] tr;
		logic signed [COORD_W-1:0] cz;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cx;
	} row_coef_t;

endpackage

// ===== rtl/vwvf_if.sv =====
// valid/ready channels of the view window vertex filter
// depends on vwvf_pkg
interface vwvf_vtx_if;
	import vwvf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic signed [COORD_W-1:0] vertex_z;
	logic [NUM_W-1:0]          vertex_number;

	modport source(output valid, vertex_x, vertex_y, vertex_z, vertex_number, input ready);
	modport sink(input valid, vertex_x, vertex_y, vertex_z, vertex_number, output ready);
endinterface

interface vwvf_sel_if;
	import vwvf_pkg::*;
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] selected_number;

	modport source(output valid, selected_number, input ready);
	modport sink(input valid, selected_number, output ready);
endinterface

// ===== rtl/view_window_vertex_filter.sv =====
// view window vertex filter: transforms each vertex into view space and selects it
// against a depth limit and a rectangle or circle window; depends on vwvf_pkg,
// vwvf_if and vwvf_xform
//
// One vertex beat is taken every clock cycle unless a stalled output holds the pipe;
// accepted vertex beats keep their order on the way out. The pipeline is five
// register stages: the nine matrix products, the exact row sums with floor and
// clamp to Q1.14, the depth test with window offsets and box compares, the two
// distance squares with the radius square, and the output register where the
// circle compare is made. All stages move together on one advance signal that is
// high whenever the output register is empty or being taken, so a stalled output
// only holds the pipe and never drops a beat. A vertex that fails the depth or
// window test leaves no beat at all. Configuration is a plain write port and must
// only be written while no vertex is in flight.
module view_window_vertex_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [vwvf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vwvf_pkg::CFG_DATA_W-1:0]      cfg_data,
	vwvf_vtx_if.sink                             vtx,
	vwvf_sel_if.source                           sel
);
	import vwvf_pkg::*;

	localparam int unsigned DIFF_W = VIEW_W + 1;
	localparam int unsigned SQ_W   = 2 * DIFF_W;

	// configuration registers
	logic [CFG_DATA_W-1:0]  mat_q [6];
	logic [CFG_DATA_W-1:0]  win_q;
	logic [DEPTH_REG_W-1:0] dm_q;

	// window fields
	logic signed [VIEW_W-1:0] cx, cy, wr, ht, minz;
	logic                     circle;

	// pipeline control
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic num_ok;

	// payload
	logic [NUM_W-1:0]         num_s1, num_s2, num_s3, num_s4, out_num_q;
	logic signed [VIEW_W-1:0] view_s2 [3];
	row_coef_t                rows [3];

	logic signed [DIFF_W-1:0] vx_e, vy_e, xlo, xhi, ylo, yhi, cx_w, cy_h;
	logic signed [DIFF_W-1:0] dx_s3, dy_s3;
	logic                     depth_ok_s3, in_box_s3, depth_ok_s4, in_box_s4;
	logic [SQ_W-1:0]          dxx_s4, dyy_s4;
	logic [2*VIEW_W-1:0]      rr_s4;
	logic [SQ_W:0]            dist_sq;
	logic                     keep;

	// config writes; indexes past the list do nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= RST_MAT_X_LO;
			mat_q[1] <= RST_MAT_X_HI;
			mat_q[2] <= RST_MAT_Y_LO;
			mat_q[3] <= RST_MAT_Y_HI;
			mat_q[4] <= RST_MAT_Z_LO;
			mat_q[5] <= RST_MAT_Z_HI;
			win_q    <= RST_WINDOW;
			dm_q     <= RST_DEPTH_MODE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAT_X_LO:   mat_q[0] <= cfg_data;
				REG_MAT_X_HI:   mat_q[1] <= cfg_data;
				REG_MAT_Y_LO:   mat_q[2] <= cfg_data;
				REG_MAT_Y_HI:   mat_q[3] <= cfg_data;
				REG_MAT_Z_LO:   mat_q[4] <= cfg_data;
				REG_MAT_Z_HI:   mat_q[5] <= cfg_data;
				REG_WINDOW:     win_q    <= cfg_data;
				REG_DEPTH_MODE: dm_q     <= cfg_data[DEPTH_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cx     = win_q[15:0];
	assign cy     = win_q[31:16];
	assign wr     = win_q[47:32];
	assign ht     = win_q[63:48];
	assign minz   = dm_q[VIEW_W-1:0];
	assign circle = dm_q[VIEW_W];

	// whole pipe moves when the output register is free or being drained
	assign adv       = !out_v_q || sel.ready;
	assign vtx.ready = adv;
	assign num_ok    = 32'(vtx.vertex_number) < 32'(MAX_VERTICES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= vtx.valid && num_ok;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			out_v_q <= v_s4 && keep;
		end
	end

	// stages 1 and 2: one transform unit per view axis
	for (genvar r = 0; r < 3; r++) begin : g_row
		assign rows[r] = {mat_q[2*r+1][63:32], mat_q[2*r+1][31:0],
			mat_q[2*r][63:32], mat_q[2*r][31:0]};
		vwvf_xform u_xform (
			.clk     (clk),
			.en      (adv),
			.row     (rows[r]),
			.x       (vtx.vertex_x),
			.y       (vtx.vertex_y),
			.z       (vtx.vertex_z),
			.view_s2 (view_s2[r])
		);
	end

	// stage 3: depth test, offsets from the centre, closed box test
	always_comb begin
		vx_e = {view_s2[0][VIEW_W-1], view_s2[0]};
		vy_e = {view_s2[1][VIEW_W-1], view_s2[1]};
		// corner plus extent at 17 bits, no clamp
		cx_w = {cx[VIEW_W-1], cx} + {wr[VIEW_W-1], wr};
		cy_h = {cy[VIEW_W-1], cy} + {ht[VIEW_W-1], ht};
		// non-positive extent puts the corner at the top end
		if (wr > 0) begin
			xlo = {cx[VIEW_W-1], cx};
			xhi = cx_w;
		end else begin
			xlo = cx_w;
			xhi = {cx[VIEW_W-1], cx};
		end
		if (ht > 0) begin
			ylo = {cy[VIEW_W-1], cy};
			yhi = cy_h;
		end else begin
			ylo = cy_h;
			yhi = {cy[VIEW_W-1], cy};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1      <= vtx.vertex_number;
			num_s2      <= num_s1;
			num_s3      <= num_s2;
			depth_ok_s3 <= view_s2[2] >= minz;
			in_box_s3   <= (xlo <= vx_e) && (vx_e <= xhi) && (ylo <= vy_e) && (vy_e <= yhi);
			dx_s3       <= vx_e - {cx[VIEW_W-1], cx};
			dy_s3       <= vy_e - {cy[VIEW_W-1], cy};
		end
	end

	// stage 4: squares of the offsets and of the radius
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4      <= num_s3;
			depth_ok_s4 <= depth_ok_s3;
			in_box_s4   <= in_box_s3;
			dxx_s4      <= SQ_W'(dx_s3 * dx_s3);
			dyy_s4      <= SQ_W'(dy_s3 * dy_s3);
			rr_s4       <= (2*VIEW_W)'(wr * wr);
		end
	end

	// output stage: circle compare, a negative radius never matches
	always_comb begin
		dist_sq = {1'b0, dxx_s4} + {1'b0, dyy_s4};
		if (!depth_ok_s4) begin
			keep = 1'b0;
		end else if (circle) begin
			keep = !wr[VIEW_W-1] && (dist_sq <= (SQ_W+1)'(rr_s4));
		end else begin
			keep = in_box_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_num_q <= num_s4;
		end
	end

	assign sel.valid           = out_v_q;
	assign sel.selected_number = out_num_q;

`ifndef SYNTH
	a_depth_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && adv && !depth_ok_s4 |=> !out_v_q)
		else $error("vertex below minimum depth reached the output");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4}) && $stable(num_s4))
		else $error("pipeline moved while stalled");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s4) && $past(adv))
		else $error("output beat without a vertex in the last stage");
`endif

endmodule

// ===== rtl/vwvf_xform.sv =====
// one row of the affine view transform: products, then exact sum, floor and saturate
// depends on vwvf_pkg
module vwvf_xform (
	input  logic                                   clk,
	input  logic                                   en,
	input  vwvf_pkg::row_coef_t                    row,
	input  logic signed [vwvf_pkg::COORD_W-1:0]    x,
	input  logic signed [vwvf_pkg::COORD_W-1:0]    y,
	input  logic signed [vwvf_pkg::COORD_W-1:0]    z,
	output logic signed [vwvf_pkg::VIEW_W-1:0]     view_s2
);
	import vwvf_pkg::*;

	localparam int unsigned PROD_W = 2 * COORD_W;
	localparam int unsigned SUM_W  = PROD_W + 2;
	localparam int unsigned SHIFT  = 18;

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  tr_term;
	logic                     fits;

	// stage 1: three 32x32 products
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= row.cx * x;
			py_s1 <= row.cy * y;
			pz_s1 <= row.cz * z;
		end
	end

	// stage 2: exact sum, floor by shift, clamp to q1.14
	always_comb begin
		tr_term = {{(SUM_W-COORD_W-16){row.tr[COORD_W-1]}}, row.tr, 16'h0000};
		sum = {{2{px_s1[PROD_W-1]}}, px_s1} + {{2{py_s1[PROD_W-1]}}, py_s1}
			+ {{2{pz_s1[PROD_W-1]}}, pz_s1} + tr_term;
		fits = (&sum[SUM_W-1:SHIFT+VIEW_W-1]) | ~(|sum[SUM_W-1:SHIFT+VIEW_W-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fits) begin
				view_s2 <= sum[SHIFT+VIEW_W-1:SHIFT];
			end else if (sum[SUM_W-1]) begin
				view_s2 <= {1'b1, {(VIEW_W-1){1'b0}}};
			end else begin
				view_s2 <= {1'b0, {(VIEW_W-1){1'b1}}};
			end
		end
	end

endmodule

// ===== dv/view_window_vertex_filter_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the view window vertex filter: class tracking expected indexes,
// plain tasks for vertex beats and register writes; depends on rtl vwvf_pkg, vwvf_if
// and view_window_vertex_filter
import vwvf_pkg::*;

// predicts which vertex indexes come out and checks them in order
class selection_tracker;
	logic [CFG_DATA_W-1:0] shadow [8];
	logic [NUM_W-1:0] expected_numbers [$];
	int mismatches;

	function new();
		shadow[REG_MAT_X_LO] = RST_MAT_X_LO;
		shadow[REG_MAT_X_HI] = RST_MAT_X_HI;
		shadow[REG_MAT_Y_LO] = RST_MAT_Y_LO;
		shadow[REG_MAT_Y_HI] = RST_MAT_Y_HI;
		shadow[REG_MAT_Z_LO] = RST_MAT_Z_LO;
		shadow[REG_MAT_Z_HI] = RST_MAT_Z_HI;
		shadow[REG_WINDOW] = RST_WINDOW;
		shadow[REG_DEPTH_MODE] = CFG_DATA_W'(RST_DEPTH_MODE);
		mismatches = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		if (idx == REG_DEPTH_MODE)
			shadow[idx] = data & ((64'd1 << DEPTH_REG_W) - 1);
		else
			shadow[idx] = data;
	endfunction

	function int pending();
		return expected_numbers.size();
	endfunction

	// exact Q32.32 row sum, floor into Q.14, clamp to Q1.14
	function logic signed [VIEW_W-1:0] view_coord(logic [CFG_DATA_W-1:0] lo,
			logic [CFG_DATA_W-1:0] hi, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
		logic signed [65:0] kx, ky, kz, kt, acc, q;
		kx = $signed(lo[31:0]);
		ky = $signed(lo[63:32]);
		kz = $signed(hi[31:0]);
		kt = $signed(hi[63:32]);
		acc = kx * x + ky * y + kz * z + (kt <<< 16);
		q = acc >>> 18;
		if (q > 32767)
			return 16'sh7FFF;
		if (q < -32768)
			return 16'sh8000;
		return q[VIEW_W-1:0];
	endfunction

	function void note_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic signed [COORD_W-1:0] z, logic [NUM_W-1:0] num);
		int cx, cy, w, h, minz, vx, vy, vz, xlo, xhi, ylo, yhi;
		longint dx, dy;
		bit keep;
		logic [CFG_DATA_W-1:0] win;
		win = shadow[REG_WINDOW];
		cx = $signed(win[15:0]);
		cy = $signed(win[31:16]);
		w = $signed(win[47:32]);
		h = $signed(win[63:48]);
		minz = $signed(shadow[REG_DEPTH_MODE][15:0]);
		if (num >= MAX_VERTICES)
			return;
		vx = view_coord(shadow[REG_MAT_X_LO], shadow[REG_MAT_X_HI], x, y, z);
		vy = view_coord(shadow[REG_MAT_Y_LO], shadow[REG_MAT_Y_HI], x, y, z);
		vz = view_coord(shadow[REG_MAT_Z_LO], shadow[REG_MAT_Z_HI], x, y, z);
		if (vz < minz)
			return;
		if (shadow[REG_DEPTH_MODE][16]) begin
			dx = vx - cx;
			dy = vy - cy;
			keep = (w >= 0) && (dx * dx + dy * dy <= longint'(w) * w);
		end else begin
			xlo = cx;
			xhi = cx;
			ylo = cy;
			yhi = cy;
			if (w > 0)
				xhi = cx + w;
			else
				xlo = cx + w;
			if (h > 0)
				yhi = cy + h;
			else
				ylo = cy + h;
			keep = xlo <= vx && vx <= xhi && ylo <= vy && vy <= yhi;
		end
		if (keep)
			expected_numbers.push_back(num);
	endfunction

	function void check_selection(logic [NUM_W-1:0] actual);
		logic [NUM_W-1:0] want;
		if (expected_numbers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("selected_number %0d arrived with nothing pending", actual);
		end else begin
			want = expected_numbers.pop_front();
			if (want !== actual) begin
				mismatches++;
				if (mismatches <= 10)
					$display("selected_number mismatch: expected %0d, actual %0d", want, actual);
			end
		end
	endfunction
endclass

module view_window_vertex_filter_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;   // covers the pipeline stages, with margin
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vwvf_vtx_if vtx_ch();
	vwvf_sel_if sel_ch();

	view_window_vertex_filter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.vtx(vtx_ch),
		.sel(sel_ch)
	);

	selection_tracker tracker = new();

	// register image loaded as a whole between phases
	logic [CFG_DATA_W-1:0] cfg_img [8];

	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	// view-space target of aimed vertices in the current phase
	int aim_cx, aim_sx, aim_cy, aim_sy, aim_cz;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// every accepted vertex beat feeds the predictor
	always @(posedge clk) begin
		if (arst_n && vtx_ch.valid && vtx_ch.ready)
			tracker.note_vertex(vtx_ch.vertex_x, vtx_ch.vertex_y, vtx_ch.vertex_z,
				vtx_ch.vertex_number);
	end

	// every accepted selection beat is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && sel_ch.valid && sel_ch.ready)
			tracker.check_selection(sel_ch.selected_number);
	end

	// receiver: random back-pressure, or a long hold-off when asked for
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			sel_ch.ready <= 1'b0;
		end else begin
			sel_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// uniform over [-half, half]
	function automatic int rand_span(int half);
		return int'($urandom_range(2 * half)) - half;
	endfunction

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	// model coordinate: mostly within +-1.5, some full range, some extremes
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return rand_span(98304);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] rand_coef();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'h0000_0000;
			2: return 32'h0001_0000;
			3: return 32'hFFFF_0000;
			default: return rand_span(49152);
		endcase
	endfunction

	// identity matrix maps a coordinate to floor(coord / 4) in view space
	function automatic logic [COORD_W-1:0] aim_coord(int centre, int spread);
		return (centre + rand_span(spread)) * 4 + int'($urandom_range(3));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] window_word(int cx, int cy, int w, int h);
		return {h[15:0], w[15:0], cy[15:0], cx[15:0]};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] depth_word(int minz, bit circ);
		return CFG_DATA_W'({circ, minz[15:0]});
	endfunction

	task automatic set_identity();
		cfg_img[REG_MAT_X_LO] = RST_MAT_X_LO;
		cfg_img[REG_MAT_X_HI] = RST_MAT_X_HI;
		cfg_img[REG_MAT_Y_LO] = RST_MAT_Y_LO;
		cfg_img[REG_MAT_Y_HI] = RST_MAT_Y_HI;
		cfg_img[REG_MAT_Z_LO] = RST_MAT_Z_LO;
		cfg_img[REG_MAT_Z_HI] = RST_MAT_Z_HI;
	endtask

	// one write per cycle, all eight registers; called at a falling edge with the pipe empty
	task automatic load_config();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= cfg_img[i];
			tracker.write_reg(i[CFG_IDX_W-1:0], cfg_img[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// one vertex beat with random idle cycles in front; returns at a falling edge
	task automatic send_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z, input logic [NUM_W-1:0] num);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		vtx_ch.valid <= 1'b1;
		vtx_ch.vertex_x <= x;
		vtx_ch.vertex_y <= y;
		vtx_ch.vertex_z <= z;
		vtx_ch.vertex_number <= num;
		@(posedge clk);
		while (!vtx_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// sender pauses until all selections are out, then dropped vertices may still be in flight
	task automatic drain_pipe();
		vtx_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic randomize_config(input bit aimed);
		row_coef_t row;
		int cx, cy, w, h, minz;
		bit circ;
		if (aimed) begin
			set_identity();
		end else begin
			// low/high register pair per matrix row
			for (int r = 0; r < 3; r++) begin
				row.cx = rand_coef();
				row.cy = rand_coef();
				row.cz = rand_coef();
				row.tr = ($urandom_range(6) == 0) ? $urandom : rand_span(32768);
				cfg_img[2 * r] = row[63:0];
				cfg_img[2 * r + 1] = row[127:64];
			end
		end
		circ = $urandom_range(1);
		cx = rand_span(12000);
		cy = rand_span(12000);
		h = ($urandom_range(9) == 0) ? rand_span(32768) : rand_span(12000);
		if (circ) begin
			// radius mostly positive, now and then any 16-bit value
			w = ($urandom_range(9) == 0) ? rand_span(32768) : int'($urandom_range(12000));
			aim_cx = cx;
			aim_cy = cy;
			aim_sx = mag(w) + 40;
			aim_sy = mag(w) + 40;
		end else begin
			case ($urandom_range(9))
				0: w = rand_span(32768);
				1: w = 0;
				default: w = rand_span(12000);
			endcase
			if ($urandom_range(9) == 0)
				h = 0;
			aim_cx = cx + w / 2;
			aim_cy = cy + h / 2;
			aim_sx = mag(w) / 2 + 40;
			aim_sy = mag(h) / 2 + 40;
		end
		case ($urandom_range(7))
			0, 1: minz = -32768;
			2: minz = rand_span(32768);
			default: minz = rand_span(8000);
		endcase
		aim_cz = minz + 100;
		cfg_img[REG_WINDOW] = window_word(cx, cy, w, h);
		cfg_img[REG_DEPTH_MODE] = depth_word(minz, circ);
	endtask

	// aimed vertices land around the window and the depth limit, the rest is noise
	task automatic run_random_phase(input bit aimed, input int count);
		logic [COORD_W-1:0] x, y, z;
		for (int i = 0; i < count; i++) begin
			if (aimed && $urandom_range(4) != 0) begin
				x = aim_coord(aim_cx, aim_sx);
				y = aim_coord(aim_cy, aim_sy);
				z = aim_coord(aim_cz, 400);
			end else begin
				x = rand_coord();
				y = rand_coord();
				z = rand_coord();
			end
			send_vertex(x, y, z, NUM_W'($urandom_range(65535)));
		end
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vtx_ch.valid = 1'b0;
		vtx_ch.vertex_x = '0;
		vtx_ch.vertex_y = '0;
		vtx_ch.vertex_z = '0;
		vtx_ch.vertex_number = '0;
		sel_ch.ready = 1'b0;
		send_idle_pct = 29;
		recv_idle_pct = 79;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset setup: identity, zero window, min depth at the floor
		send_vertex(32'd0, 32'd0, 32'd0, 16'd0);
		send_vertex(32'd0, 32'd0, 32'd0, 16'hFFFF);
		send_vertex(32'd1, -32'sd1, 32'd0, 16'd2);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd3);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd4);
		send_vertex(32'd0, 32'd0, -32'sd131072, 16'd5);
		drain_pipe();

		// closed box with negative height, depth limit at zero
		set_identity();
		cfg_img[REG_WINDOW] = window_word(1000, -1000, 2000, -3000);
		cfg_img[REG_DEPTH_MODE] = depth_word(0, 1'b0);
		load_config();
		send_vertex(32'd4000, -32'sd16000, 32'd0, 16'd7);
		send_vertex(32'd12000, -32'sd4000, 32'd0, 16'd8);
		send_vertex(32'd3996, -32'sd8000, 32'd0, 16'd9);
		send_vertex(32'd12004, -32'sd8000, 32'd0, 16'd10);
		send_vertex(32'd8000, -32'sd16004, 32'd0, 16'd11);
		send_vertex(32'd8000, -32'sd8000, -32'sd1, 16'd12);
		send_vertex(32'd8000, -32'sd8000, 32'd0, 16'd13);
		drain_pipe();

		// box limits past the 16-bit range, met by saturated views
		cfg_img[REG_WINDOW] = window_word(30000, -30000, 30000, -30000);
		cfg_img[REG_DEPTH_MODE] = depth_word(-32768, 1'b0);
		load_config();
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 16'd14);
		send_vertex(32'd120000, -32'sd120000, 32'd0, 16'd15);
		send_vertex(32'd119996, -32'sd120000, 32'd0, 16'd16);
		drain_pipe();

		// zero width and height: a single point
		cfg_img[REG_WINDOW] = window_word(500, 500, 0, 0);
		load_config();
		send_vertex(32'd2000, 32'd2000, 32'd0, 16'd17);
		send_vertex(32'd2004, 32'd2000, 32'd0, 16'd18);
		drain_pipe();

		// circle of radius 1000 around the origin, edge points on and just off
		cfg_img[REG_WINDOW] = window_word(0, 0, 1000, 0);
		cfg_img[REG_DEPTH_MODE] = depth_word(-32768, 1'b1);
		load_config();
		send_vertex(32'd4000, 32'd0, 32'd0, 16'd19);
		send_vertex(32'd4004, 32'd0, 32'd0, 16'd20);
		send_vertex(32'd2400, 32'd3200, 32'd0, 16'd21);
		send_vertex(32'd2404, 32'd3200, 32'd0, 16'd22);
		send_vertex(-32'sd2400, -32'sd3200, 32'd0, 16'd23);
		drain_pipe();

		// negative radius keeps nothing, not even the centre
		cfg_img[REG_WINDOW] = window_word(0, 0, -1, 0);
		load_config();
		send_vertex(32'd0, 32'd0, 32'd0, 16'd24);
		drain_pipe();

		// random phases, alternating aimed identity and random matrices
		for (int p = 0; p < 12; p++) begin
			if (p == 4) begin
				send_idle_pct = 79;
				recv_idle_pct = 29;
			end else if (p == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			randomize_config(p[0]);
			load_config();
			run_random_phase(p[0], 130);
			drain_pipe();
		end

		// largest positive values everywhere
		for (int i = 0; i < 6; i++)
			cfg_img[i] = 64'h7FFF_FFFF_7FFF_FFFF;
		cfg_img[REG_WINDOW] = 64'h7FFF_7FFF_7FFF_7FFF;
		cfg_img[REG_DEPTH_MODE] = depth_word(32767, 1'b0);
		load_config();
		run_random_phase(1'b0, 40);
		drain_pipe();

		// all ones everywhere, circle mode with negative radius
		for (int i = 0; i < 8; i++)
			cfg_img[i] = 64'hFFFF_FFFF_FFFF_FFFF;
		load_config();
		run_random_phase(1'b0, 40);
		drain_pipe();

		// zero matrix keeps every vertex; long receiver hold fills the pipe
		for (int i = 0; i < 6; i++)
			cfg_img[i] = 64'h0;
		cfg_img[REG_WINDOW] = window_word(0, 0, 0, 0);
		cfg_img[REG_DEPTH_MODE] = depth_word(-32768, 1'b0);
		load_config();
		hold_request = 1'b1;
		run_random_phase(1'b0, 60);
		drain_pipe();

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vwvf_pkg.sv
rtl/vwvf_if.sv
rtl/vwvf_xform.sv
rtl/view_window_vertex_filter.sv
dv/view_window_vertex_filter_tb.sv
